/* hw/rtl/stq_pkg.sv */
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;

    localparam int EVENT_ID_W = 8;
    localparam int TICK_W     = 32;
    // Ids are masked to ID_WIDTH bits and the event_id field is only 8 bits wide.
    localparam int KEY_W      = (ID_WIDTH < EVENT_ID_W) ? ID_WIDTH : EVENT_ID_W;

    typedef logic [KEY_W-1:0]  key_id_t;
    typedef logic [TICK_W-1:0] tick_t;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_CANCEL  = 2'd1,
        KIND_ADVANCE = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_DUP_ID    = 2'd3
    } status_t;

    typedef enum logic {
        RK_FIRED = 1'b0,
        RK_DONE  = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LEFT  = 2'd1,
        OP_NEW   = 2'd2,
        OP_RIGHT = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [EVENT_ID_W-1:0] event_id;
        logic [TICK_W-1:0]     delay;
        logic [TICK_W-1:0]     tick_step;
        logic                  notify_on_cancel;
    } in_item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [EVENT_ID_W-1:0] fired_id;
        logic [1:0]            status;
        logic [TICK_W-1:0]     current_tick;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic    valid;
        tick_t   expiry;
        key_id_t id;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        key_id_t  key_id;
        tick_t    key_exp;
    } cell_ctl_t;

    typedef struct packed {
        logic match;
        logic after;
    } cell_flags_t;

    function automatic result_t make_result(result_kind_t rk, key_id_t id, status_t st,
                                            tick_t tick);
        result_t r;
        r.result_kind  = rk;
        r.fired_id     = EVENT_ID_W'(id);
        r.status       = st;
        r.current_tick = tick;
        r.last         = (rk == RK_DONE);
        return r;
    endfunction

endpackage

/* hw/rtl/sorted_timer_event_queue.sv */
// Channel   Direction  Handshake                       Payload
// --------  ---------  ------------------------------  -----------------------------
// item      in         transfer when start && !busy    kind, id, delay, step, notify
// result    out        transfer on result_strobe       kind, id, status, tick, last
//
// Every item is accepted in ST_IDLE and then executed on the cell chain in ST_EXEC.
// A cancel that reports the removed event then passes ST_DONE; an advance goes on
// to ST_POP, which pops each due event from the head cell and then emits the done marker.
// Results leave from an output register, one per cycle; the receiver cannot stall.
// Reset clears the tick count and every cell's valid bit; no clearing pass is needed.
module sorted_timer_event_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  stq_pkg::in_item_t item,
    output logic              result_strobe,
    output stq_pkg::result_t  result
);
    import stq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_DONE = 4'b0100,
        ST_POP  = 4'b1000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    kind_t   kind_reg;
    logic    notify_reg;
    key_id_t key_id_reg;
    tick_t   key_exp_reg;
    tick_t   tick_reg;
    tick_t   tick_next;
    logic    strobe_reg;
    logic    strobe_next;
    result_t result_reg;
    result_t result_next;

    cell_ctl_t             ctl     [QUEUE_DEPTH];
    cell_op_t              op_vec  [QUEUE_DEPTH];
    entry_t                ent     [QUEUE_DEPTH];
    entry_t                left_e  [QUEUE_DEPTH];
    entry_t                right_e [QUEUE_DEPTH];
    cell_flags_t           flg     [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] match_vec;
    logic [QUEUE_DEPTH-1:0] after_vec;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [QUEUE_DEPTH-1:0] from_match;
    logic                   head_due;
    logic                   accept;

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // Build the chain: each cell sees both neighbors; the tail shifts in an empty slot.
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        assign ctl[g].op      = op_vec[g];
        assign ctl[g].key_id  = key_id_reg;
        assign ctl[g].key_exp = key_exp_reg;
        assign match_vec[g]   = flg[g].match;
        assign after_vec[g]   = flg[g].after;
        assign valid_vec[g]   = ent[g].valid;

        if (g == 0)
        begin : g_head
            assign left_e[g] = '0;
        end
        else
        begin : g_mid
            assign left_e[g] = ent[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_e[g] = '0;
        end
        else
        begin : g_body
            assign right_e[g] = ent[g+1];
        end

        stq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[g]),
            .left_ent  (left_e[g]),
            .right_ent (right_e[g]),
            .ent       (ent[g]),
            .flags     (flg[g])
        );
    end

    // Ids are unique, so the match vector is one-hot or zero: ~(m - 1) marks
    // the matching slot and every slot behind it.
    assign from_match = ~(match_vec - QUEUE_DEPTH'(1));
    assign head_due   = ent[0].valid && (ent[0].expiry <= tick_reg);

    always_comb
    begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            op_vec[i] = OP_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                    if (kind_t'(item.kind) == KIND_ADVANCE)
                        tick_next = tick_reg + item.tick_step;
                end
            end
            ST_EXEC:
            begin
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
                result_next = make_result(RK_DONE, '0, STATUS_OK, tick_reg);
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (|match_vec)
                            result_next = make_result(RK_DONE, '0, STATUS_DUP_ID, tick_reg);
                        else if (valid_vec[QUEUE_DEPTH-1])
                            result_next = make_result(RK_DONE, '0, STATUS_FULL, tick_reg);
                        else
                        begin
                            // Open a gap at the first slot not earlier than the key.
                            for (int i = 0; i < QUEUE_DEPTH; i++)
                            begin
                                if (after_vec[i])
                                    op_vec[i] = (i > 0 && after_vec[(i > 0) ? i - 1 : 0])
                                              ? OP_LEFT : OP_NEW;
                            end
                        end
                    end
                    KIND_CANCEL:
                    begin
                        if (!(|match_vec))
                            result_next = make_result(RK_DONE, '0, STATUS_NOT_FOUND,
                                                      tick_reg);
                        else
                        begin
                            // Close the gap left by the cancelled entry.
                            for (int i = 0; i < QUEUE_DEPTH; i++)
                            begin
                                if (from_match[i])
                                    op_vec[i] = OP_RIGHT;
                            end
                            if (notify_reg)
                            begin
                                result_next = make_result(RK_FIRED, key_id_reg, STATUS_OK,
                                                          tick_reg);
                                state_next  = ST_DONE;
                            end
                        end
                    end
                    KIND_ADVANCE:
                    begin
                        strobe_next = 1'b0;
                        state_next  = ST_POP;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DONE:
            begin
                strobe_next = 1'b1;
                result_next = make_result(RK_DONE, '0, STATUS_OK, tick_reg);
                state_next  = ST_IDLE;
            end
            ST_POP:
            begin
                strobe_next = 1'b1;
                if (head_due)
                begin
                    // Emit the head and advance the whole chain by one slot.
                    result_next = make_result(RK_FIRED, ent[0].id, STATUS_OK, tick_reg);
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                        op_vec[i] = OP_RIGHT;
                end
                else
                begin
                    result_next = make_result(RK_DONE, '0, STATUS_OK, tick_reg);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tick_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold the item's fields for the execute cycle; the add key uses the old tick.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            kind_reg    <= kind_t'(item.kind);
            notify_reg  <= item.notify_on_cancel;
            key_id_reg  <= item.event_id[KEY_W-1:0];
            key_exp_reg <= tick_reg + item.delay;
        end
    end

`ifndef NO_ASSERTIONS
    // Valid slots stay packed from the head: the valid vector plus one is a power of two.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + (QUEUE_DEPTH + 1)'(1)))
        else $error("queue entries not packed from the head");

    // The id of the executing item is held in at most one cell.
    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $onehot0(match_vec))
        else $error("id held in more than one cell");

    // A pop pass that finds no due head ends the item with its done marker.
    a_pop_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP && !head_due) |=>
            (result_strobe && result.last && state_reg == ST_IDLE))
        else $error("advance did not end with a done marker");
`endif

endmodule

/* hw/rtl/stq_cell.sv */
module stq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stq_pkg::cell_ctl_t   ctl,
    input  stq_pkg::entry_t      left_ent,
    input  stq_pkg::entry_t      right_ent,
    output stq_pkg::entry_t      ent,
    output stq_pkg::cell_flags_t flags
);
    import stq_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    tick_t   expiry_reg;
    tick_t   expiry_next;
    key_id_t id_reg;
    key_id_t id_next;

    assign ent.valid  = valid_reg;
    assign ent.expiry = expiry_reg;
    assign ent.id     = id_reg;

    // Slot is at or past the insertion point when empty or not earlier than the key.
    assign flags.match = valid_reg && (id_reg == ctl.key_id);
    assign flags.after = !valid_reg || (ctl.key_exp <= expiry_reg);

    always_comb
    begin
        valid_next  = valid_reg;
        expiry_next = expiry_reg;
        id_next     = id_reg;
        case (ctl.op)
            OP_LEFT:
            begin
                valid_next  = left_ent.valid;
                expiry_next = left_ent.expiry;
                id_next     = left_ent.id;
            end
            OP_NEW:
            begin
                valid_next  = 1'b1;
                expiry_next = ctl.key_exp;
                id_next     = ctl.key_id;
            end
            OP_RIGHT:
            begin
                valid_next  = right_ent.valid;
                expiry_next = right_ent.expiry;
                id_next     = right_ent.id;
            end
            default:
            begin
                valid_next  = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        id_reg     <= id_next;
    end

endmodule

/* dv/tb_top.sv */
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import stq_pkg::*;

    // One queued command: idle cycles to hold before it, then the item itself.
    typedef struct {
        int unsigned gap;
        in_item_t    payload;
    } timer_cmd_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    in_item_t item;
    logic     result_strobe;
    result_t  result;

    sorted_timer_event_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // Commands waiting to go out, and results the timer queue owes us.
    timer_cmd_t cmd_backlog[$];
    result_t    predicted_results[$];

    // Shadow of the timer: tick counter plus the sorted, packed slot list.
    tick_t   mdl_tick;
    tick_t   mdl_exp [QUEUE_DEPTH];
    key_id_t mdl_id  [QUEUE_DEPTH];
    logic    mdl_vld [QUEUE_DEPTH];

    int fail_count;
    int fired_seen;
    int done_seen;
    int kind_seen [4];

    // Set by the monitor when a transfer happens at a rising edge; the driver
    // reads it at the following falling edge to know the held item is gone.
    bit xfer_seen;

    // Driver-local bookkeeping.
    int unsigned idle_left;
    bit          gap_taken;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model of the timer queue
    // ------------------------------------------------------------------

    function automatic void queue_result(result_kind_t rk, key_id_t id, status_t st);
        result_t res;
        res.result_kind  = rk;
        res.fired_id     = (rk == RK_FIRED) ? EVENT_ID_W'(id) : '0;
        res.status       = st;
        res.current_tick = mdl_tick;
        res.last         = (rk == RK_DONE);
        predicted_results.push_back(res);
    endfunction

    // Close the gap at slot p and free the tail slot.
    function automatic void drop_slot(int p);
        int i;
        for (i = p; i < QUEUE_DEPTH - 1; i++)
        begin
            mdl_exp[i] = mdl_exp[i + 1];
            mdl_id[i]  = mdl_id[i + 1];
            mdl_vld[i] = mdl_vld[i + 1];
        end
        mdl_vld[QUEUE_DEPTH - 1] = 1'b0;
    endfunction

    // Apply one accepted command to the shadow state and queue what it owes.
    function automatic void model_timer_cmd(in_item_t cmd);
        key_id_t key;
        key_id_t due_id;
        status_t st;
        tick_t   expiry;
        int      hit;
        int      pos;
        int      i;
        key = cmd.event_id[KEY_W-1:0];
        st  = STATUS_OK;
        hit = -1;
        for (i = 0; i < QUEUE_DEPTH; i++)
            if (hit < 0 && mdl_vld[i] && mdl_id[i] == key)
                hit = i;
        case (kind_t'(cmd.kind))
            KIND_ADD:
            begin
                if (hit >= 0)
                    st = STATUS_DUP_ID;
                else if (mdl_vld[QUEUE_DEPTH - 1])
                    st = STATUS_FULL;
                else
                begin
                    // New event lands ahead of every entry with equal or later expiry.
                    expiry = mdl_tick + cmd.delay;
                    pos = 0;
                    while (pos < QUEUE_DEPTH && mdl_vld[pos] && expiry > mdl_exp[pos])
                        pos++;
                    for (i = QUEUE_DEPTH - 1; i > pos; i--)
                    begin
                        mdl_exp[i] = mdl_exp[i - 1];
                        mdl_id[i]  = mdl_id[i - 1];
                        mdl_vld[i] = mdl_vld[i - 1];
                    end
                    mdl_exp[pos] = expiry;
                    mdl_id[pos]  = key;
                    mdl_vld[pos] = 1'b1;
                end
            end
            KIND_CANCEL:
            begin
                if (hit < 0)
                    st = STATUS_NOT_FOUND;
                else
                begin
                    drop_slot(hit);
                    if (cmd.notify_on_cancel)
                        queue_result(RK_FIRED, key, STATUS_OK);
                end
            end
            KIND_ADVANCE:
            begin
                // Tick wraps; then pop every head entry that is now due.
                mdl_tick = mdl_tick + cmd.tick_step;
                while (mdl_vld[0] && mdl_exp[0] <= mdl_tick)
                begin
                    due_id = mdl_id[0];
                    drop_slot(0);
                    queue_result(RK_FIRED, due_id, STATUS_OK);
                end
            end
            default:
                ;
        endcase
        queue_result(RK_DONE, '0, st);
    endfunction

    function automatic void push_cmd(kind_t k, logic [EVENT_ID_W-1:0] id, tick_t dly,
                                     tick_t stp, logic ntf, int unsigned gap);
        timer_cmd_t c;
        c.gap                      = gap;
        c.payload.kind             = k;
        c.payload.event_id         = id;
        c.payload.delay            = dly;
        c.payload.tick_step        = stp;
        c.payload.notify_on_cancel = ntf;
        cmd_backlog.push_back(c);
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge only
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        // Hold the current item until a transfer has taken it.
        if (rst_n && (!start || xfer_seen))
        begin
            if (idle_left != 0)
            begin
                start <= 1'b0;
                idle_left = idle_left - 1;
            end
            else if (!gap_taken && cmd_backlog.size() != 0 && cmd_backlog[0].gap != 0)
            begin
                // Open the idle stretch requested ahead of the next item.
                start <= 1'b0;
                idle_left = cmd_backlog[0].gap - 1;
                gap_taken = 1'b1;
            end
            else if (cmd_backlog.size() != 0)
            begin
                item  <= cmd_backlog[0].payload;
                start <= 1'b1;
                void'(cmd_backlog.pop_front());
                gap_taken = 1'b0;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge, predict on transfer, check results
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (!rst_n)
            xfer_seen = 1'b0;
        else
        begin
            xfer_seen = start && !busy;
            // Predict first so a result in the same edge always finds its expectation.
            if (xfer_seen)
            begin
                model_timer_cmd(item);
                kind_seen[item.kind]++;
            end
            if ($isunknown(result_strobe))
            begin
                $display("%0t ns: result_strobe unknown, expected 0 or 1, got %b",
                         $time, result_strobe);
                fail_count++;
            end
            else if (result_strobe)
            begin
                if (result.result_kind == RK_DONE)
                    done_seen++;
                else
                    fired_seen++;
                if (predicted_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, got kind=%0d id=%0d",
                             $time, result.result_kind, result.fired_id);
                    $display("    status=%0d tick=%0d last=%0d",
                             result.status, result.current_tick, result.last);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t ns: result mismatch", $time);
                        $display("    expected kind=%0d id=%0d status=%0d tick=%0d last=%0d",
                                 want.result_kind, want.fired_id, want.status,
                                 want.current_tick, want.last);
                        $display("    actual   kind=%0d id=%0d status=%0d tick=%0d last=%0d",
                                 result.result_kind, result.fired_id, result.status,
                                 result.current_tick, result.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int                    n;
        int unsigned           r;
        int unsigned           gap;
        kind_t                 k;
        logic [EVENT_ID_W-1:0] id;
        tick_t                 dly;
        tick_t                 stp;

        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        xfer_seen  = 1'b0;
        idle_left  = 0;
        gap_taken  = 1'b0;
        fail_count = 0;
        fired_seen = 0;
        done_seen  = 0;
        kind_seen  = '{default: 0};
        mdl_tick   = '0;
        mdl_exp    = '{default: '0};
        mdl_id     = '{default: '0};
        mdl_vld    = '{default: 1'b0};

        // Directed part. Read ignores delay and step, so drive them all ones.
        push_cmd(KIND_READ, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
        // Cancel of an id that is not queued.
        push_cmd(KIND_CANCEL, 8'h5A, '0, '0, 1'b1, 1);
        // Equal expiry: the later add goes ahead of the earlier one.
        push_cmd(KIND_ADD, 8'hFF, 32'd10, '0, 1'b0, 0);
        push_cmd(KIND_ADD, 8'h00, 32'd10, '0, 1'b0, 0);
        // Duplicate id on add.
        push_cmd(KIND_ADD, 8'hFF, 32'd3, '0, 1'b0, 2);
        // Cancel with notification.
        push_cmd(KIND_CANCEL, 8'h00, '0, '0, 1'b1, 0);
        // Fill every slot with interleaved expiries and ties.
        for (n = 0; n < QUEUE_DEPTH - 1; n++)
            push_cmd(KIND_ADD, 8'(8'h10 + n * 7), tick_t'((n * 5) % 9), '0, 1'b0,
                     (n % 3 == 0) ? 1 : 0);
        // Add to a full queue, then a duplicate while full: duplicate wins.
        push_cmd(KIND_ADD, 8'h80, 32'd1, '0, 1'b0, 0);
        push_cmd(KIND_ADD, 8'hFF, 32'd1, '0, 1'b0, 0);
        // Jump the tick to all ones: every slot fires in one advance.
        push_cmd(KIND_ADVANCE, 8'h00, '0, 32'hFFFF_FFFF, 1'b0, 0);
        // Expiry wraps below the tick, so the next advance of zero fires it.
        push_cmd(KIND_ADD, 8'h01, 32'hFFFF_FFFF, '0, 1'b0, 0);
        push_cmd(KIND_ADVANCE, 8'h00, '0, '0, 1'b0, 0);

        // Random part: a small id pool keeps duplicates, hits and full queues
        // common; every other block of twenty runs back to back with no idling.
        for (n = 0; n < 180; n++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                k = KIND_ADD;
            else if (r < 6)
                k = KIND_CANCEL;
            else if (r < 9)
                k = KIND_ADVANCE;
            else
                k = KIND_READ;

            id = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 23));

            r = $urandom_range(0, 9);
            if (r < 7)
                dly = $urandom_range(0, 40);
            else if (r < 9)
                dly = $urandom_range(0, 1000);
            else
                dly = $urandom;

            r = $urandom_range(0, 9);
            if (r < 6)
                stp = $urandom_range(0, 15);
            else if (r < 9)
                stp = $urandom_range(0, 100);
            else
                stp = $urandom;

            if ((n / 20) % 2 == 0)
                gap = 0;
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    gap = 0;
                else if (r < 9)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(8, 30);
            end

            push_cmd(k, id, dly, stp, 1'($urandom_range(0, 1)), gap);
        end

        // Hold reset, then release it on a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all items taken, every owed result seen, then a quiet tail.
        wait (cmd_backlog.size() == 0 && !start);
        wait (predicted_results.size() == 0);
        repeat (40) @(posedge clk);

        $display("Covered %0d adds, %0d cancels, %0d advances, %0d reads;",
                 kind_seen[KIND_ADD], kind_seen[KIND_CANCEL],
                 kind_seen[KIND_ADVANCE], kind_seen[KIND_READ]);
        $display("checked %0d fired events and %0d done markers.", fired_seen, done_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run well past the slowest legal completion.
    initial
    begin
        #1_000_000;
        $display("Timeout: %0d results still owed", predicted_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timer_event_queue.sv
dv/tb_top.sv
